/* hdl/jvc_pkg.sv */
`default_nettype none

package jvc_pkg;

  typedef struct packed {
    logic               op;
    logic [31:0]        now_ms;
    logic               btn_enable;
    logic               btn_light;
    logic               btn_buzzer;
    logic               btn_linear_gear;
    logic               btn_angular_gear;
    logic signed [15:0] axis_forward;
    logic signed [15:0] axis_sideways;
    logic signed [15:0] axis_turn;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic               flag_value;
    logic [2:0]         light_index;
    logic signed [15:0] speed_forward;
    logic signed [15:0] speed_sideways;
    logic signed [15:0] speed_turn;
    logic               last;
  } out_word_t;

  localparam logic [1:0] KIND_ENABLE = 2'd0;
  localparam logic [1:0] KIND_BUZZER = 2'd1;
  localparam logic [1:0] KIND_LIGHT  = 2'd2;
  localparam logic [1:0] KIND_TWIST  = 2'd3;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam int CFG_AW = 5;

  localparam logic [2:0] REG_DEAD_ZONE      = 3'd0;
  localparam logic [2:0] REG_FORWARD_LIMIT  = 3'd1;
  localparam logic [2:0] REG_SIDEWAYS_LIMIT = 3'd2;
  localparam logic [2:0] REG_TURN_LIMIT     = 3'd3;
  localparam logic [2:0] REG_ENABLE_LOCKOUT = 3'd4;
  localparam logic [2:0] REG_BUTTON_LOCKOUT = 3'd5;

  localparam logic [14:0] DEAD_ZONE_RST      = 15'd6554;
  localparam logic [14:0] FORWARD_LIMIT_RST  = 15'd4096;
  localparam logic [14:0] SIDEWAYS_LIMIT_RST = 15'd4096;
  localparam logic [14:0] TURN_LIMIT_RST     = 15'd6144;
  localparam logic [15:0] ENABLE_LOCKOUT_RST = 16'd1000;
  localparam logic [15:0] BUTTON_LOCKOUT_RST = 16'd250;

  localparam logic [1:0] AXIS_FORWARD  = 2'd0;
  localparam logic [1:0] AXIS_SIDEWAYS = 2'd1;
  localparam logic [1:0] AXIS_TURN     = 2'd2;

  localparam int BTN_ENABLE  = 0;
  localparam int BTN_LIGHT   = 1;
  localparam int BTN_BUZZER  = 2;
  localparam int BTN_LINEAR  = 3;
  localparam int BTN_ANGULAR = 4;
  localparam int BTN_COUNT   = 5;

  localparam int PEND_ENABLE = 0;
  localparam int PEND_TWIST  = 1;
  localparam int PEND_LIGHT  = 2;
  localparam int PEND_BUZZER = 3;

  typedef struct packed {
    logic [14:0] dead_zone;
    logic [14:0] forward_limit;
    logic [14:0] sideways_limit;
    logic [14:0] turn_limit;
    logic [15:0] enable_lockout_ms;
    logic [15:0] button_lockout_ms;
  } cfg_t;

  typedef struct packed {
    logic       capture;
    logic       decide;
    logic       mul1;
    logic       mul2;
    logic       store;
    logic       emit;
    logic [1:0] axis;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic pend_empty;
    logic out_free;
  } dp_stat_t;

  function automatic logic [15:0] lin_gear(input logic [1:0] sel);
    logic [15:0] g;
    unique case (sel)
      2'd0:    g = 16'd32768;
      2'd1:    g = 16'd21845;
      default: g = 16'd10922;
    endcase
    return g;
  endfunction

  function automatic logic [15:0] ang_gear(input logic [1:0] sel);
    logic [15:0] g;
    unique case (sel)
      2'd0:    g = 16'd32768;
      2'd1:    g = 16'd24576;
      2'd2:    g = 16'd16384;
      default: g = 16'd8192;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

/* hdl/joystick_velocity_commander.sv */
`default_nettype none

// Joystick velocity commander. A sample word (op 0) updates the enable, buzzer, light and gear
// state from its buttons and scales the three axes into held speeds; a tick word (op 1) emits
// the held twist while remote control is active and moving, or one zero twist once it stops.
// Each input word is processed on its own: a sample passes through decide, then multiply,
// multiply and store for each axis, then emits its result words (at most four); a tick goes
// from decide straight to emit. The one shared 16 by 16 multiplier serves every axis twice.
// A finished result waits in the output register, and the next input word can be accepted
// while it does. Results of one input leave in order, and the final one carries last.

module joystick_velocity_commander #(
  parameter int LIGHT_COUNT = 7,
  parameter int TIME_WIDTH  = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire jvc_pkg::in_word_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output jvc_pkg::out_word_t              out_data,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [jvc_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]                cfg_pwdata,
  output logic      [31:0]                cfg_prdata,
  output logic                            cfg_pready
);

  jvc_pkg::cfg_t     cfg;
  jvc_pkg::dp_cmd_t  cmd;
  jvc_pkg::dp_stat_t stat;

  jvc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  jvc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  jvc_dp #(
    .LIGHT_COUNT (LIGHT_COUNT),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* hdl/jvc_regs.sv */
`default_nettype none

module jvc_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [jvc_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]                cfg_pwdata,
  output logic      [31:0]                cfg_prdata,
  output logic                            cfg_pready,
  output jvc_pkg::cfg_t                   cfg
);

  jvc_pkg::cfg_t cfg_r;
  logic [2:0]    idx;
  logic          wr_en;

  assign idx        = cfg_paddr[jvc_pkg::CFG_AW-1:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dead_zone         <= jvc_pkg::DEAD_ZONE_RST;
      cfg_r.forward_limit     <= jvc_pkg::FORWARD_LIMIT_RST;
      cfg_r.sideways_limit    <= jvc_pkg::SIDEWAYS_LIMIT_RST;
      cfg_r.turn_limit        <= jvc_pkg::TURN_LIMIT_RST;
      cfg_r.enable_lockout_ms <= jvc_pkg::ENABLE_LOCKOUT_RST;
      cfg_r.button_lockout_ms <= jvc_pkg::BUTTON_LOCKOUT_RST;
    end else if (wr_en) begin
      unique case (idx)
        jvc_pkg::REG_DEAD_ZONE:      cfg_r.dead_zone         <= cfg_pwdata[14:0];
        jvc_pkg::REG_FORWARD_LIMIT:  cfg_r.forward_limit     <= cfg_pwdata[14:0];
        jvc_pkg::REG_SIDEWAYS_LIMIT: cfg_r.sideways_limit    <= cfg_pwdata[14:0];
        jvc_pkg::REG_TURN_LIMIT:     cfg_r.turn_limit        <= cfg_pwdata[14:0];
        jvc_pkg::REG_ENABLE_LOCKOUT: cfg_r.enable_lockout_ms <= cfg_pwdata[15:0];
        jvc_pkg::REG_BUTTON_LOCKOUT: cfg_r.button_lockout_ms <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      jvc_pkg::REG_DEAD_ZONE:      cfg_prdata = {17'd0, cfg_r.dead_zone};
      jvc_pkg::REG_FORWARD_LIMIT:  cfg_prdata = {17'd0, cfg_r.forward_limit};
      jvc_pkg::REG_SIDEWAYS_LIMIT: cfg_prdata = {17'd0, cfg_r.sideways_limit};
      jvc_pkg::REG_TURN_LIMIT:     cfg_prdata = {17'd0, cfg_r.turn_limit};
      jvc_pkg::REG_ENABLE_LOCKOUT: cfg_prdata = {16'd0, cfg_r.enable_lockout_ms};
      jvc_pkg::REG_BUTTON_LOCKOUT: cfg_prdata = {16'd0, cfg_r.button_lockout_ms};
      default:                     cfg_prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/jvc_ctrl.sv */
`default_nettype none

module jvc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire jvc_pkg::dp_stat_t stat,
  output jvc_pkg::dp_cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL1,
    ST_MUL2,
    ST_STORE,
    ST_EMIT
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        axis_nxt  = jvc_pkg::AXIS_FORWARD;
        state_nxt = stat.is_tick ? ST_EMIT : ST_MUL1;
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_STORE;
      ST_STORE: begin
        if (axis_r == jvc_pkg::AXIS_TURN) begin
          state_nxt = ST_EMIT;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = ST_MUL1;
        end
      end
      ST_EMIT: begin
        if (stat.pend_empty) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= jvc_pkg::AXIS_FORWARD;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd.capture = (state_r == ST_IDLE) && in_valid;
    cmd.decide  = (state_r == ST_DECIDE);
    cmd.mul1    = (state_r == ST_MUL1);
    cmd.mul2    = (state_r == ST_MUL2);
    cmd.store   = (state_r == ST_STORE);
    cmd.emit    = (state_r == ST_EMIT) && !stat.pend_empty && stat.out_free;
    cmd.axis    = axis_r;
  end

endmodule

`default_nettype wire

/* hdl/jvc_dp.sv */
`default_nettype none

module jvc_dp #(
  parameter int LIGHT_COUNT = 7,
  parameter int TIME_WIDTH  = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire jvc_pkg::cfg_t      cfg,
  input  wire jvc_pkg::in_word_t  in_data,
  input  wire jvc_pkg::dp_cmd_t   cmd,
  output jvc_pkg::dp_stat_t       stat,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output jvc_pkg::out_word_t      out_data
);

  localparam int LW = $clog2(LIGHT_COUNT);

  jvc_pkg::in_word_t  in_r;
  jvc_pkg::out_word_t out_r;
  jvc_pkg::out_word_t out_nxt;
  logic               out_valid_r;

  logic                  remote_r, buzzer_r, was_moving_r;
  logic [LW-1:0]         light_r;
  logic [1:0]            lin_sel_r, ang_sel_r;
  logic [TIME_WIDTH-1:0] press_r [jvc_pkg::BTN_COUNT];
  logic signed [15:0]    held_r [3];
  logic [31:0]           prod_r;
  logic [3:0]            pend_r;
  logic                  twist_held_r;

  logic [TIME_WIDTH+31:0] now_ext;
  logic [TIME_WIDTH-1:0]  now_t;
  logic [TIME_WIDTH+15:0] en_lock_ext, btn_lock_ext;
  logic [TIME_WIDTH-1:0]  lock_t [jvc_pkg::BTN_COUNT];
  logic [TIME_WIDTH-1:0]  diff [jvc_pkg::BTN_COUNT];
  logic [jvc_pkg::BTN_COUNT-1:0] btn_v, ok;

  logic [LW:0]   light_inc;
  logic [LW-1:0] light_nxt;
  logic [LW+2:0] light_wide;
  logic          moving;

  logic signed [15:0] axis_v;
  logic [15:0]        mag;
  logic [14:0]        limit;
  logic [15:0]        gear;
  logic [15:0]        mul_a, mul_b;
  logic [16:0]        scaled;
  logic [14:0]        clamped;
  logic               dead;
  logic signed [15:0] speed;

  logic [3:0] pick, pend_left;

  assign now_ext      = {{TIME_WIDTH{1'b0}}, in_r.now_ms};
  assign now_t        = now_ext[TIME_WIDTH-1:0];
  assign en_lock_ext  = {{TIME_WIDTH{1'b0}}, cfg.enable_lockout_ms};
  assign btn_lock_ext = {{TIME_WIDTH{1'b0}}, cfg.button_lockout_ms};

  always_comb begin
    btn_v[jvc_pkg::BTN_ENABLE]  = in_r.btn_enable;
    btn_v[jvc_pkg::BTN_LIGHT]   = in_r.btn_light;
    btn_v[jvc_pkg::BTN_BUZZER]  = in_r.btn_buzzer;
    btn_v[jvc_pkg::BTN_LINEAR]  = in_r.btn_linear_gear;
    btn_v[jvc_pkg::BTN_ANGULAR] = in_r.btn_angular_gear;
    for (int k = 0; k < jvc_pkg::BTN_COUNT; k++) begin
      lock_t[k] = (k == jvc_pkg::BTN_ENABLE) ? en_lock_ext[TIME_WIDTH-1:0]
                                             : btn_lock_ext[TIME_WIDTH-1:0];
      diff[k]   = now_t - press_r[k];
      ok[k]     = btn_v[k] && (diff[k] > lock_t[k]);
    end
  end

  assign light_inc  = {1'b0, light_r} + (LW+1)'(1);
  assign light_nxt  = (light_inc >= (LW+1)'(LIGHT_COUNT)) ? '0 : light_inc[LW-1:0];
  assign light_wide = {3'd0, light_r};
  assign moving     = (held_r[0] != 16'sd0) || (held_r[1] != 16'sd0) || (held_r[2] != 16'sd0);

  always_comb begin
    unique case (cmd.axis)
      jvc_pkg::AXIS_FORWARD: begin
        axis_v = in_r.axis_forward;
        limit  = cfg.forward_limit;
        gear   = jvc_pkg::lin_gear(lin_sel_r);
      end
      jvc_pkg::AXIS_SIDEWAYS: begin
        axis_v = in_r.axis_sideways;
        limit  = cfg.sideways_limit;
        gear   = jvc_pkg::lin_gear(lin_sel_r);
      end
      default: begin
        axis_v = in_r.axis_turn;
        limit  = cfg.turn_limit;
        gear   = jvc_pkg::ang_gear(ang_sel_r);
      end
    endcase
    mag     = axis_v[15] ? (~axis_v + 16'd1) : axis_v;
    mul_a   = cmd.mul2 ? prod_r[30:15] : mag;
    mul_b   = cmd.mul2 ? gear : {1'b0, limit};
    scaled  = prod_r[31:15];
    clamped = (scaled > {2'd0, limit}) ? limit : scaled[14:0];
    dead    = mag < {1'b0, cfg.dead_zone};
    if (dead) begin
      speed = 16'sd0;
    end else if (axis_v[15]) begin
      speed = -$signed({1'b0, clamped});
    end else begin
      speed = $signed({1'b0, clamped});
    end
  end

  always_comb begin
    priority if (pend_r[jvc_pkg::PEND_ENABLE]) begin
      pick = 4'b0001;
    end else if (pend_r[jvc_pkg::PEND_TWIST]) begin
      pick = 4'b0010;
    end else if (pend_r[jvc_pkg::PEND_LIGHT]) begin
      pick = 4'b0100;
    end else begin
      pick = 4'b1000;
    end
    pend_left = pend_r & ~pick;
  end

  always_comb begin
    out_nxt      = '0;
    out_nxt.last = (pend_left == 4'd0);
    if (pick[jvc_pkg::PEND_ENABLE]) begin
      out_nxt.kind       = jvc_pkg::KIND_ENABLE;
      out_nxt.flag_value = remote_r;
    end else if (pick[jvc_pkg::PEND_TWIST]) begin
      out_nxt.kind = jvc_pkg::KIND_TWIST;
      if (twist_held_r) begin
        out_nxt.speed_forward  = held_r[0];
        out_nxt.speed_sideways = held_r[1];
        out_nxt.speed_turn     = held_r[2];
      end
    end else if (pick[jvc_pkg::PEND_LIGHT]) begin
      out_nxt.kind        = jvc_pkg::KIND_LIGHT;
      out_nxt.light_index = light_wide[2:0];
    end else begin
      out_nxt.kind       = jvc_pkg::KIND_BUZZER;
      out_nxt.flag_value = buzzer_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r <= in_data;
    end
    if (cmd.mul1 || cmd.mul2) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.emit) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remote_r     <= 1'b0;
      buzzer_r     <= 1'b0;
      was_moving_r <= 1'b0;
      light_r      <= '0;
      lin_sel_r    <= 2'd0;
      ang_sel_r    <= 2'd0;
      for (int k = 0; k < jvc_pkg::BTN_COUNT; k++) begin
        press_r[k] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        held_r[i] <= 16'sd0;
      end
      pend_r       <= 4'd0;
      twist_held_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.decide) begin
        if (in_r.op == jvc_pkg::OP_TICK) begin
          if (remote_r && moving) begin
            pend_r       <= 4'b0010;
            twist_held_r <= 1'b1;
            was_moving_r <= 1'b1;
          end else if (remote_r && was_moving_r) begin
            pend_r       <= 4'b0010;
            twist_held_r <= 1'b0;
            was_moving_r <= 1'b0;
          end else begin
            pend_r <= 4'd0;
          end
        end else begin
          for (int k = 0; k < jvc_pkg::BTN_COUNT; k++) begin
            if (ok[k]) begin
              press_r[k] <= now_t;
            end
          end
          if (ok[jvc_pkg::BTN_ENABLE]) begin
            remote_r <= !remote_r;
          end
          if (ok[jvc_pkg::BTN_LIGHT]) begin
            light_r <= light_nxt;
          end
          if (ok[jvc_pkg::BTN_BUZZER]) begin
            buzzer_r <= !buzzer_r;
          end
          if (ok[jvc_pkg::BTN_LINEAR]) begin
            lin_sel_r <= (lin_sel_r >= 2'd2) ? 2'd0 : lin_sel_r + 2'd1;
          end
          if (ok[jvc_pkg::BTN_ANGULAR]) begin
            ang_sel_r <= ang_sel_r + 2'd1;
          end
          pend_r       <= {ok[jvc_pkg::BTN_BUZZER], ok[jvc_pkg::BTN_LIGHT],
                           ok[jvc_pkg::BTN_ENABLE], ok[jvc_pkg::BTN_ENABLE]};
          twist_held_r <= 1'b0;
        end
      end else if (cmd.emit) begin
        pend_r <= pend_left;
      end
      if (cmd.store) begin
        held_r[cmd.axis] <= speed;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.is_tick    = (in_r.op == jvc_pkg::OP_TICK);
  assign stat.pend_empty = (pend_r == 4'd0);
  assign stat.out_free   = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_data        = out_r;

endmodule

`default_nettype wire

/* hdl/jvc_checker.sv */
`default_nettype none

module jvc_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire jvc_pkg::out_word_t out_data
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a word is still in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed or dropped");

  a_enable_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == jvc_pkg::KIND_ENABLE) |-> !out_data.last)
    else $error("enable result not followed by its zero twist");

  a_speeds_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind != jvc_pkg::KIND_TWIST) |->
      (out_data.speed_forward == 16'sd0 && out_data.speed_sideways == 16'sd0 &&
       out_data.speed_turn == 16'sd0))
    else $error("speeds set on a result that is not a twist");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind joystick_velocity_commander jvc_checker u_jvc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
